// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also runs through reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/fbfla_pkg.sv =====
// package with widths, codes and helpers of the block allocator
package fbfla_pkg;

  // field widths
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned ST_W  = 2;

  // pool limits
  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned INDEX_LIMIT    = 1024;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(1024);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

  // usable pool size for a written block count
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] bc,
                                                 input int unsigned max_blocks);
    logic [CNT_W-1:0] n;
    n = bc;
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(INDEX_LIMIT)) n = CNT_W'(INDEX_LIMIT);
    if (32'(n) > max_blocks) n = CNT_W'(max_blocks);
    return n;
  endfunction

endpackage

// ===== rtl/fbfla_if.sv =====
// valid/ready channel interfaces of the block allocator

// request channel
interface fbfla_in_if import fbfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] block_index;
  modport source (output valid, output operation, output block_index, input ready);
  modport sink (input valid, input operation, input block_index, output ready);
endinterface

// result channel
interface fbfla_out_if import fbfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] granted_index;
  logic             granted;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] used_blocks;
  modport source (output valid, output granted_index, output granted, output status,
                  output used_blocks, input ready);
  modport sink (input valid, input granted_index, input granted, input status,
                input used_blocks, output ready);
endinterface

// block count write channel
interface fbfla_cfg_if import fbfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] pool_blocks;
  modport source (output valid, output pool_blocks, input ready);
  modport sink (input valid, input pool_blocks, output ready);
endinterface

// ===== rtl/fixed_block_free_list_allocator_unit.sv =====
// top level of the fixed block free list allocator
//
// Hands out block indices from a pool and takes them back. Requests enter on
// in_ch (allocate, free one index, free all), one result leaves on out_ch for
// every request. cfg_ch writes the block count, which restarts the pool empty;
// it is always ready. The user must write it only while no request is in flight;
// the block does not enforce this. Allocation gives never-used blocks lowest
// first, then freed blocks in the order they were freed.
// Path: request register with the in-use bit read, then the result
// register; each holds its item while the stage after it stalls.
// Throughput: 1 item per cycle while out_ch.ready stays high; the in-use
// bit memory and the freed-index queue each take one write and one read per
// cycle, with the queue head prefetched and both reads forwarded from the
// write in the same cycle.
// Reset: empty pool, block count 1024, both stages empty; no clearing pass,
// in-use bits count only below the fresh counter.
// Stall: the result register holds while out_ch.ready is low, the request
// register takes one more item, then in_ch.ready drops.
module fixed_block_free_list_allocator_unit import fbfla_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  fbfla_in_if.sink      in_ch,
  fbfla_out_if.source   out_ch,
  fbfla_cfg_if.sink     cfg_ch
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned FW = $clog2(MAX_BLOCKS + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(MAX_BLOCKS - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(MAX_BLOCKS);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return ext[AW-1:0];
  endfunction

  // storage
  logic [IDX_W-1:0] queue_mem [MAX_BLOCKS];
  logic             use_mem   [MAX_BLOCKS];

  // control state
  logic             s1_valid_r, out_valid_r;
  logic [CNT_W-1:0] eff_count_r, eff_count_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;

  // payload registers
  logic [OP_W-1:0]  s1_op_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_bit_r;
  logic [IDX_W-1:0] head_r;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic             out_granted_r, out_granted_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_used_r;

  // handshakes
  logic          in_fire, cfg_fire, advance;
  logic [AW-1:0] in_addr;

  // memory write controls
  logic             q_we;
  logic             u_we;
  logic [AW-1:0]    u_waddr;
  logic             u_wdata;
  logic [IDX_W-1:0] pick;
  logic             bad_free;

  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_addr  = to_addr(in_ch.block_index);

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !s1_valid_r || advance;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.granted_index = out_index_r;
  assign out_ch.granted       = out_granted_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.used_blocks   = out_used_r;

  // execute one request against the pool state
  always_comb begin
    eff_count_nxt   = eff_count_r;
    fresh_nxt       = fresh_r;
    rptr_nxt        = rptr_r;
    wptr_nxt        = wptr_r;
    fill_nxt        = fill_r;
    used_nxt        = used_r;
    q_we            = 1'b0;
    u_we            = 1'b0;
    u_waddr         = to_addr(s1_idx_r);
    u_wdata         = 1'b0;
    pick            = '0;
    bad_free        = 1'b0;
    out_index_nxt   = '0;
    out_granted_nxt = 1'b0;
    out_status_nxt  = ST_OK;
    if (cfg_fire) begin
      eff_count_nxt = eff_count(cfg_ch.pool_blocks, MAX_BLOCKS);
      fresh_nxt     = '0;
      rptr_nxt      = '0;
      wptr_nxt      = '0;
      fill_nxt      = '0;
      used_nxt      = '0;
    end else if (advance) begin
      case (s1_op_r)
        OP_ALLOC: begin
          if (fresh_r < eff_count_r) begin
            pick            = fresh_r[IDX_W-1:0];
            fresh_nxt       = fresh_r + 1'b1;
            out_granted_nxt = 1'b1;
          end else if (fill_r != '0) begin
            pick            = head_r;
            rptr_nxt        = ring_next(rptr_r);
            fill_nxt        = fill_r - 1'b1;
            out_granted_nxt = 1'b1;
          end else begin
            out_status_nxt = ST_EMPTY;
          end
          if (out_granted_nxt) begin
            u_we          = 1'b1;
            u_waddr       = to_addr(pick);
            u_wdata       = 1'b1;
            used_nxt      = used_r + 1'b1;
            out_index_nxt = pick;
          end
        end
        OP_FREE: begin
          // in-use bits at or above the fresh counter are stale from an earlier pool
          bad_free = ({1'b0, s1_idx_r} >= eff_count_r) || ({1'b0, s1_idx_r} >= fresh_r)
                     || !s1_bit_r || (fill_r >= FILL_MAX);
          if (bad_free) begin
            out_status_nxt = ST_BAD_FREE;
          end else begin
            u_we     = 1'b1;
            q_we     = 1'b1;
            wptr_nxt = ring_next(wptr_r);
            fill_nxt = fill_r + 1'b1;
            if (used_r != '0) used_nxt = used_r - 1'b1;
          end
        end
        OP_FREE_ALL: begin
          fresh_nxt = '0;
          rptr_nxt  = '0;
          wptr_nxt  = '0;
          fill_nxt  = '0;
          used_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      eff_count_r <= eff_count(BLOCK_COUNT_RST, MAX_BLOCKS);
      fresh_r     <= '0;
      rptr_r      <= '0;
      wptr_r      <= '0;
      fill_r      <= '0;
      used_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      eff_count_r <= eff_count_nxt;
      fresh_r     <= fresh_nxt;
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
    end
  end

  // request register with the in-use bit, forwarded from a same-cycle write
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= in_ch.operation;
      s1_idx_r <= in_ch.block_index;
      s1_bit_r <= (u_we && (u_waddr == in_addr)) ? u_wdata : use_mem[in_addr];
    end
    if (u_we) begin
      use_mem[u_waddr] <= u_wdata;
    end
  end

  // freed-index queue with the head prefetched at the next read pointer
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[wptr_r] <= s1_idx_r;
    end
    head_r <= (q_we && (wptr_r == rptr_nxt)) ? s1_idx_r : queue_mem[rptr_nxt];
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_index_r   <= out_index_nxt;
      out_granted_r <= out_granted_nxt;
      out_status_r  <= out_status_nxt;
      out_used_r    <= used_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_count_balance, (32'(used_r) + 32'(fill_r)) == 32'(fresh_r), "given blocks neither in use nor queued")
  `ASSERT_CLK(a_used_bound, used_r <= eff_count_r, "blocks in use exceed pool size")
  `ASSERT_CLK(a_grant_ok, out_valid_r && out_granted_r |-> (out_status_r == ST_OK) && (out_used_r != '0), "grant with bad status or zero count")
  `ASSERT_RST(a_reset_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "stages not empty after reset")

endmodule
